>>> src/apv_pkg.sv
`timescale 1ns / 1ps

package apv_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 13;
    localparam int COMP_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [BYTE_W-1:0]  SLASH_CHAR = 8'h2F;
    localparam logic [BYTE_W-1:0]  DOT_CHAR   = 8'h2E;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
    localparam logic [COMP_W-1:0]  COMP_MAX   = 8'd255;

    localparam logic [COMP_W-1:0]  NAME_LIMIT_RST = 8'd255;
    localparam logic [COUNT_W-1:0] PATH_LIMIT_RST = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_LIMIT = 2'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_NOT_ABS   = 3'd2,
        ST_DOUBLE    = 3'd3,
        ST_LONG_COMP = 3'd4,
        ST_DOT       = 3'd5,
        ST_DOTDOT    = 3'd6
    } status_t;

    // One byte handed from the input register to the tracker.
    typedef struct packed {
        logic              adv;
        logic [BYTE_W-1:0] path_byte;
        logic              is_last;
    } step_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] path_length;
    } result_t;

endpackage

>>> src/apv_if.sv
`timescale 1ns / 1ps

interface apv_in_if import apv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] path_byte;
    logic              is_last;

    modport source (output valid, output path_byte, output is_last, input ready);
    modport sink (input valid, input path_byte, input is_last, output ready);
endinterface

interface apv_out_if import apv_pkg::*; ();
    logic               valid;
    logic               ready;
    status_t            status;
    logic [COUNT_W-1:0] path_length;

    modport source (output valid, output status, output path_length, input ready);
    modport sink (input valid, input status, input path_length, output ready);
endinterface

interface apv_cfg_if import apv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/apv_tracker.sv
`timescale 1ns / 1ps

module apv_tracker import apv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COMP_W-1:0]  name_limit,
    input  logic [COUNT_W-1:0] path_limit,
    input  step_t              step,
    output result_t            result
);

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COMP_W-1:0]  comp_count_reg, comp_count_next;
    logic               prev_slash_reg, prev_slash_next;
    logic               all_dots_reg, all_dots_next;
    status_t            first_error_reg;

    // Error code raised when a component of the given length closes.
    function automatic status_t close_code(input logic [COMP_W-1:0] cc,
                                           input logic all_dots,
                                           input logic [COMP_W-1:0] limit);
        status_t code;
        code = ST_OK;
        if (cc != '0)
        begin
            if (cc >= limit)
                code = ST_LONG_COMP;
            else if (all_dots && cc == 8'd1)
                code = ST_DOT;
            else if (all_dots && cc == 8'd2)
                code = ST_DOTDOT;
        end
        return code;
    endfunction

    always_comb
    begin
        status_t err;
        status_t closing;
        logic    first;

        first = (byte_count_reg == '0);
        err   = first_error_reg;

        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 13'd1;
        comp_count_next = comp_count_reg;
        all_dots_next   = all_dots_reg;
        prev_slash_next = prev_slash_reg;

        if (step.path_byte == SLASH_CHAR)
        begin
            if (!first)
            begin
                if (prev_slash_reg)
                begin
                    if (err == ST_OK)
                        err = ST_DOUBLE;
                end
                else
                begin
                    closing = close_code(comp_count_reg, all_dots_reg, name_limit);
                    if (err == ST_OK)
                        err = closing;
                end
            end
            prev_slash_next = 1'b1;
            comp_count_next = '0;
            all_dots_next   = 1'b1;
        end
        else
        begin
            if (first && err == ST_OK)
                err = ST_NOT_ABS;
            prev_slash_next = 1'b0;
            if (comp_count_reg != COMP_MAX)
                comp_count_next = comp_count_reg + 8'd1;
            if (comp_count_next >= name_limit && err == ST_OK)
                err = ST_LONG_COMP;
            if (step.path_byte != DOT_CHAR)
                all_dots_next = 1'b0;
        end

        // The final component closes at the last byte as well.
        closing = close_code(comp_count_next, all_dots_next, name_limit);
        if (err == ST_OK)
            err = closing;

        if (byte_count_next > path_limit)
        begin
            result.status      = ST_TOO_LONG;
            result.path_length = (path_limit == COUNT_MAX) ? COUNT_MAX
                                                           : path_limit + 13'd1;
        end
        else
        begin
            result.status      = err;
            result.path_length = byte_count_next;
        end
    end

    // The closing check above must not be kept in the running error unless the
    // byte is the last one, so the stored error uses the pre-close value.
    status_t err_keep;

    always_comb
    begin
        err_keep = first_error_reg;
        if (step.path_byte == SLASH_CHAR)
        begin
            if (byte_count_reg != '0 && err_keep == ST_OK)
                err_keep = prev_slash_reg ? ST_DOUBLE
                         : close_code(comp_count_reg, all_dots_reg, name_limit);
        end
        else
        begin
            if (byte_count_reg == '0 && err_keep == ST_OK)
                err_keep = ST_NOT_ABS;
            if (comp_count_next >= name_limit && err_keep == ST_OK)
                err_keep = ST_LONG_COMP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            comp_count_reg  <= '0;
            prev_slash_reg  <= 1'b0;
            all_dots_reg    <= 1'b1;
            first_error_reg <= ST_OK;
        end
        else if (step.adv)
        begin
            if (step.is_last)
            begin
                byte_count_reg  <= '0;
                comp_count_reg  <= '0;
                prev_slash_reg  <= 1'b0;
                all_dots_reg    <= 1'b1;
                first_error_reg <= ST_OK;
            end
            else
            begin
                byte_count_reg  <= byte_count_next;
                comp_count_reg  <= comp_count_next;
                prev_slash_reg  <= prev_slash_next;
                all_dots_reg    <= all_dots_next;
                first_error_reg <= err_keep;
            end
        end
    end

endmodule

>>> src/absolute_path_validator.sv
`timescale 1ns / 1ps

// Channel    Modport  Request content
// path_in    sink     path_byte, is_last
// result_out source   status, path_length (one per path, after the last byte)
// cfg        sink     index, data (0: name_limit, 1: path_limit)
//
// One byte is taken every cycle unless a last byte waits on a stalled result;
// a byte goes into the input register, the tracker updates its counters and
// flags from it as it leaves that register, and the last byte of a path loads
// the result register as it leaves, so the result is offered from that
// register. A stalled result only holds back a last byte: other bytes keep
// flowing. Reset clears the counters and sets the limits to 255 and 4096; cfg
// is always ready and takes effect from the next byte.

module absolute_path_validator import apv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    apv_in_if.sink     path_in,
    apv_out_if.source  result_out,
    apv_cfg_if.sink    cfg
);

    logic [COMP_W-1:0]  name_limit_reg;
    logic [COUNT_W-1:0] path_limit_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_adv;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [COUNT_W-1:0] out_len_reg;

    step_t   step;
    result_t result;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg <= NAME_LIMIT_RST;
            path_limit_reg <= PATH_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NAME_LIMIT: name_limit_reg <= cfg.data[COMP_W-1:0];
                REG_PATH_LIMIT: path_limit_reg <= cfg.data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // A non-final byte never waits on the result side.
    assign s1_adv = s1_valid_reg &&
                    (!s1_last_reg || !out_valid_reg || result_out.ready);
    assign path_in.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (path_in.ready)
            s1_valid_reg <= path_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (path_in.valid && path_in.ready)
        begin
            s1_byte_reg <= path_in.path_byte;
            s1_last_reg <= path_in.is_last;
        end
    end

    assign step.adv       = s1_adv;
    assign step.path_byte = s1_byte_reg;
    assign step.is_last   = s1_last_reg;

    apv_tracker u_tracker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .name_limit (name_limit_reg),
        .path_limit (path_limit_reg),
        .step       (step),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_last_reg)
        begin
            out_status_reg <= result.status;
            out_len_reg    <= result.path_length;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.status      = out_status_reg;
    assign result_out.path_length = out_len_reg;

`ifndef SYNTH
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (path_in.valid && path_in.ready) |=> s1_valid_reg)
        else $error("accepted byte did not reach the input register");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_last_reg))
        else $error("result appeared without a final byte");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_byte_reg)
                                       && $stable(s1_last_reg)))
        else $error("stalled final byte was lost or changed");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_TOO_LONG && $stable(path_limit_reg))
        |-> (out_len_reg <= path_limit_reg))
        else $error("accepted path is longer than the limit");
`endif

endmodule
